// File: design/assert_macros.svh
// Assertion macros shared by the frame receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define FPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/fpr_pkg.sv
// Types and constants of the framed packet receiver
package fpr_pkg;

	// Line bytes
	localparam logic [7:0] START_BYTE  = 8'h7E;
	localparam logic [7:0] END_BYTE    = 8'h7F;
	localparam logic [7:0] FILLER_BYTE = 8'hF5;

	// Reply codes
	localparam logic [7:0] REPLY_RECEIVING = 8'hF4;
	localparam logic [7:0] REPLY_ACCEPTED  = 8'hF6;
	localparam logic [7:0] REPLY_RESEND    = 8'hF7;
	localparam logic [7:0] REPLY_NONE      = 8'h00;

	// Error kinds
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_FRAMING = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT = 2'd2;
	localparam logic [1:0] ERR_CHECK   = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

	// Register reset values
	localparam logic [7:0] IDLE_LIMIT_RST = 8'd200;
	localparam logic [7:0] MIN_LENGTH_RST = 8'd3;
	localparam logic [7:0] MAX_LENGTH_RST = 8'd34;

	// Link state, coded as reported on link_status
	typedef enum logic [1:0] {
		LS_RECEIVING = 2'd0,
		LS_HELD      = 2'd1,
		LS_GOOD      = 2'd2,
		LS_ERROR     = 2'd3
	} link_state_t;

	// Parser phase
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} rx_phase_t;

	// Outcome of one parsed byte
	typedef enum logic [1:0] {
		RX_MORE    = 2'd0,
		RX_DONE    = 2'd1,
		RX_FRAMING = 2'd2,
		RX_TIMEOUT = 2'd3
	} rx_res_t;

	// Configuration seen by the parser
	typedef struct packed {
		logic [7:0] idle_limit;
		logic [7:0] min_length;
		logic [7:0] max_length;
	} fpr_cfg_t;

	// Held frame status from the parser
	typedef struct packed {
		logic       check_ok;
		logic [7:0] head;
		logic [7:0] seq;
	} fpr_frame_t;

	// One result word
	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [1:0] link_status;
		logic [1:0] error_kind;
		logic       frame_good;
		logic [7:0] frame_head;
		logic [7:0] frame_sequence;
	} fpr_result_t;

endpackage

// File: design/fpr_channels.sv
// Valid/ready channel interfaces for input and result words

interface fpr_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface fpr_out_if;
	logic       valid;
	logic       ready;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic [1:0] link_status;
	logic [1:0] error_kind;
	logic       frame_good;
	logic [7:0] frame_head;
	logic [7:0] frame_sequence;

	modport source (output valid, output reply_valid, output reply_byte, output link_status,
		output error_kind, output frame_good, output frame_head, output frame_sequence,
		input ready);
	modport sink (input valid, input reply_valid, input reply_byte, input link_status,
		input error_kind, input frame_good, input frame_head, input frame_sequence,
		output ready);
endinterface

// File: design/fpr_frame_parser.sv
// Byte-level frame parser: start, length, body, check and end bytes, idle timeout
`include "assert_macros.svh"

module fpr_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  fpr_pkg::fpr_cfg_t  cfg,
	output fpr_pkg::rx_res_t   rx_res,
	output fpr_pkg::fpr_frame_t frame
);

	fpr_pkg::rx_phase_t phase_q, phase_d;
	logic [8:0] idx_q, idx_d;
	logic [7:0] len_q, len_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] chk_hi_q, chk_hi_d;
	logic [7:0] chk_lo_q, chk_lo_d;
	logic [7:0] end_q, end_d;
	logic [7:0] head_q, head_d;
	logic [7:0] seq_q, seq_d;
	logic [7:0] idle_q, idle_d;
	logic [8:0] len9;

	assign len9 = {1'b0, len_q};

	// Next parser state for the byte on rx_byte
	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		len_d    = len_q;
		xor_d    = xor_q;
		chk_hi_d = chk_hi_q;
		chk_lo_d = chk_lo_q;
		end_d    = end_q;
		head_d   = head_q;
		seq_d    = seq_q;
		idle_d   = idle_q;
		rx_res   = fpr_pkg::RX_MORE;
		case (phase_q)
			fpr_pkg::PH_START: begin
				idx_d = 9'd0;
				if (rx_byte == fpr_pkg::START_BYTE) begin
					phase_d = fpr_pkg::PH_LENGTH;
					idle_d  = 8'd0;
				end else if (rx_byte == fpr_pkg::FILLER_BYTE) begin
					if (idle_q > cfg.idle_limit) begin
						idle_d = 8'd0;
						rx_res = fpr_pkg::RX_TIMEOUT;
					end else begin
						idle_d = idle_q + 8'd1;
					end
				end else begin
					rx_res = fpr_pkg::RX_FRAMING;
				end
			end
			fpr_pkg::PH_LENGTH: begin
				if (rx_byte >= cfg.min_length && rx_byte <= cfg.max_length) begin
					len_d   = rx_byte;
					xor_d   = rx_byte;
					idx_d   = 9'd1;
					phase_d = fpr_pkg::PH_DATA;
				end else begin
					phase_d = fpr_pkg::PH_START;
					idx_d   = 9'd0;
					rx_res  = fpr_pkg::RX_FRAMING;
				end
			end
			fpr_pkg::PH_DATA: begin
				if (idx_q == 9'd1) head_d = rx_byte;
				if (idx_q == 9'd2) seq_d = rx_byte;
				if (idx_q <= len9) begin
					xor_d = xor_q ^ rx_byte;
				end else if (idx_q == len9 + 9'd1) begin
					chk_hi_d = rx_byte;
				end else if (idx_q == len9 + 9'd2) begin
					chk_lo_d = rx_byte;
				end else begin
					end_d = rx_byte;
				end
				if (idx_q >= len9 + 9'd3) begin
					phase_d = fpr_pkg::PH_START;
					idx_d   = 9'd0;
					rx_res  = fpr_pkg::RX_DONE;
				end else begin
					idx_d = idx_q + 9'd1;
				end
			end
			default: begin
				phase_d = fpr_pkg::PH_START;
				idx_d   = 9'd0;
				rx_res  = fpr_pkg::RX_FRAMING;
			end
		endcase
	end

	// Parser registers advance only on a byte taken while receiving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= fpr_pkg::PH_START;
			idx_q    <= 9'd0;
			len_q    <= 8'd0;
			xor_q    <= 8'd0;
			chk_hi_q <= 8'd0;
			chk_lo_q <= 8'd0;
			end_q    <= 8'd0;
			head_q   <= 8'd0;
			seq_q    <= 8'd0;
			idle_q   <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
			xor_q    <= xor_d;
			chk_hi_q <= chk_hi_d;
			chk_lo_q <= chk_lo_d;
			end_q    <= end_d;
			head_q   <= head_d;
			seq_q    <= seq_d;
			idle_q   <= idle_d;
		end
	end

	// Held frame verdict
	assign frame.check_ok = (chk_hi_q == 8'd0) && (chk_lo_q == xor_q) &&
		(end_q == fpr_pkg::END_BYTE);
	assign frame.head = head_q;
	assign frame.seq  = seq_q;

	`FPR_ASSERT(a_idx_zero_outside_body, phase_q == fpr_pkg::PH_DATA || idx_q == 9'd0,
		"byte index nonzero outside frame body")
	`FPR_ASSERT(a_idx_in_body_range,
		phase_q != fpr_pkg::PH_DATA || (idx_q != 9'd0 && idx_q <= len9 + 9'd3),
		"byte index beyond end of frame")
	`FPR_ASSERT_NEXT(a_start_to_length,
		step && phase_q == fpr_pkg::PH_START && rx_byte == fpr_pkg::START_BYTE,
		phase_q == fpr_pkg::PH_LENGTH && idle_q == 8'd0,
		"start byte did not open a frame")

endmodule

// File: design/framed_packet_receiver_core.sv
// Top level of the framed packet receiver: link state, configuration and result register
`include "assert_macros.svh"

// Takes one word per clock: a received byte (opcode 0) or a poll (opcode 1), and returns
// exactly one result word for each. All work for a word is done in the cycle it is
// accepted and lands in a single result register, so the result appears in the cycle after
// acceptance and a new word is accepted every cycle, also while a result is being taken.
// din.ready is low only while the result register is full and dout.ready is low.
// The three length/timeout registers are written through cfg_we/cfg_index/cfg_data and
// should be changed only while no word is in flight; indexes beyond the list are ignored.
module framed_packet_receiver_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	fpr_in_if.sink                         din,
	fpr_out_if.source                      dout
);

	fpr_pkg::fpr_cfg_t    cfg_q;
	fpr_pkg::link_state_t link_q, link_d;
	fpr_pkg::rx_res_t     rx_res;
	fpr_pkg::fpr_frame_t  frame;
	fpr_pkg::fpr_result_t res_d, res_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 step;

	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;
	assign step      = accept && !din.opcode && link_q == fpr_pkg::LS_RECEIVING;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_limit <= fpr_pkg::IDLE_LIMIT_RST;
			cfg_q.min_length <= fpr_pkg::MIN_LENGTH_RST;
			cfg_q.max_length <= fpr_pkg::MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fpr_pkg::CFG_IDLE_LIMIT: cfg_q.idle_limit <= cfg_data;
				fpr_pkg::CFG_MIN_LENGTH: cfg_q.min_length <= cfg_data;
				fpr_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: ;
			endcase
		end
	end

	fpr_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (din.rx_byte),
		.cfg     (cfg_q),
		.rx_res  (rx_res),
		.frame   (frame)
	);

	// Link state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= fpr_pkg::LS_RECEIVING;
		end else if (accept) begin
			link_q <= link_d;
		end
	end

	// Next link state and result word
	always_comb begin
		link_d               = link_q;
		res_d.reply_valid    = 1'b1;
		res_d.reply_byte     = fpr_pkg::REPLY_RECEIVING;
		res_d.link_status    = link_q;
		res_d.error_kind     = fpr_pkg::ERR_NONE;
		res_d.frame_good     = 1'b0;
		res_d.frame_head     = 8'd0;
		res_d.frame_sequence = 8'd0;
		if (din.opcode) begin
			// poll: judge a held frame, otherwise just report
			res_d.reply_valid = 1'b0;
			res_d.reply_byte  = fpr_pkg::REPLY_NONE;
			if (link_q == fpr_pkg::LS_HELD) begin
				link_d               = frame.check_ok ? fpr_pkg::LS_GOOD : fpr_pkg::LS_ERROR;
				res_d.link_status    = link_d;
				res_d.error_kind     = frame.check_ok ? fpr_pkg::ERR_NONE : fpr_pkg::ERR_CHECK;
				res_d.frame_good     = frame.check_ok;
				res_d.frame_head     = frame.check_ok ? frame.head : 8'd0;
				res_d.frame_sequence = frame.check_ok ? frame.seq : 8'd0;
			end
		end else begin
			case (link_q)
				fpr_pkg::LS_HELD: begin
					res_d.link_status = fpr_pkg::LS_HELD;
				end
				fpr_pkg::LS_GOOD: begin
					link_d            = fpr_pkg::LS_RECEIVING;
					res_d.reply_byte  = fpr_pkg::REPLY_ACCEPTED;
					res_d.link_status = fpr_pkg::LS_RECEIVING;
				end
				fpr_pkg::LS_ERROR: begin
					link_d            = fpr_pkg::LS_RECEIVING;
					res_d.reply_byte  = fpr_pkg::REPLY_RESEND;
					res_d.link_status = fpr_pkg::LS_RECEIVING;
				end
				default: begin
					link_d            = fpr_pkg::LS_RECEIVING;
					res_d.link_status = fpr_pkg::LS_RECEIVING;
					case (rx_res)
						fpr_pkg::RX_DONE: begin
							link_d            = fpr_pkg::LS_HELD;
							res_d.link_status = fpr_pkg::LS_HELD;
						end
						fpr_pkg::RX_FRAMING: begin
							res_d.reply_byte  = fpr_pkg::REPLY_RESEND;
							res_d.link_status = fpr_pkg::LS_ERROR;
							res_d.error_kind  = fpr_pkg::ERR_FRAMING;
						end
						fpr_pkg::RX_TIMEOUT: begin
							res_d.reply_byte  = fpr_pkg::REPLY_RESEND;
							res_d.link_status = fpr_pkg::LS_ERROR;
							res_d.error_kind  = fpr_pkg::ERR_TIMEOUT;
						end
						default: ;
					endcase
				end
			endcase
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (din.ready) begin
			out_valid_q <= din.valid;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.reply_valid    = res_q.reply_valid;
	assign dout.reply_byte     = res_q.reply_byte;
	assign dout.link_status    = res_q.link_status;
	assign dout.error_kind     = res_q.error_kind;
	assign dout.frame_good     = res_q.frame_good;
	assign dout.frame_head     = res_q.frame_head;
	assign dout.frame_sequence = res_q.frame_sequence;

	`FPR_ASSERT_NEXT(a_poll_gives_verdict,
		accept && din.opcode && link_q == fpr_pkg::LS_HELD,
		(link_q == fpr_pkg::LS_GOOD && dout.frame_good) ||
		(link_q == fpr_pkg::LS_ERROR && dout.error_kind == fpr_pkg::ERR_CHECK),
		"poll on held frame gave no verdict")
	`FPR_ASSERT_NEXT(a_done_holds_frame, step && rx_res == fpr_pkg::RX_DONE,
		link_q == fpr_pkg::LS_HELD && dout.link_status == fpr_pkg::LS_HELD,
		"completed frame not held")
	`FPR_ASSERT_NEXT(a_accept_fills_result, accept, out_valid_q,
		"accepted word produced no result")

endmodule
